FILE: hdl/fmu_pkg.sv
// Shared codes for the fuzzy membership unit: shapes, register indexes, degree select.
// No dependencies.
package fmu_pkg;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [1:0] {
      SHAPE_TRIANGLE  = 2'd0,
      SHAPE_TRAPEZOID = 2'd1,
      SHAPE_RISING    = 2'd2,
      SHAPE_FALLING   = 2'd3
   } shape_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHAPE_KIND = 3'd0,
      CSR_POINT_A    = 3'd1,
      CSR_POINT_B    = 3'd2,
      CSR_POINT_C    = 3'd3,
      CSR_POINT_D    = 3'd4
   } csr_index_type;

   // How the final degree is formed.
   typedef enum logic [1:0] {
      DEG_QUOTIENT = 2'd0,
      DEG_ONE      = 2'd1,
      DEG_ZERO     = 2'd2
   } deg_sel_type;

   localparam int DEG_SEL_WIDTH = 2;

endpackage

FILE: hdl/fmu_if.sv
// Valid/ready channel interfaces for request and response transactions.
// No dependencies.
interface fmu_req_if #(
   parameter int VALUE_WIDTH      = 16,
   parameter int DEGREE_FRAC_BITS = 15
);
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [VALUE_WIDTH-1:0] sample;
   logic [DEGREE_FRAC_BITS:0]     degree_in;

   modport source (output valid, func, sample, degree_in, input ready);
   modport sink   (input valid, func, sample, degree_in, output ready);
endinterface

interface fmu_rsp_if #(
   parameter int VALUE_WIDTH      = 16,
   parameter int DEGREE_FRAC_BITS = 15
);
   logic                          valid;
   logic                          ready;
   logic [DEGREE_FRAC_BITS:0]     degree_out;
   logic signed [VALUE_WIDTH-1:0] left_point;
   logic signed [VALUE_WIDTH-1:0] right_point;

   modport source (output valid, degree_out, left_point, right_point, input ready);
   modport sink   (input valid, degree_out, left_point, right_point, output ready);
endinterface

FILE: hdl/fmu_prep.sv
// Front stage: edge selection, divider operands and inverse-edge products.
// Depends on fmu_pkg.
module fmu_prep
   import fmu_pkg::*;
#(
   parameter int VALUE_WIDTH      = 16,
   parameter int DEGREE_FRAC_BITS = 15,
   localparam int PROD_WIDTH      = VALUE_WIDTH + DEGREE_FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic                          func,
   input  logic signed [VALUE_WIDTH-1:0] sample,
   input  logic [DEGREE_FRAC_BITS:0]     degree_in,
   input  shape_type                     shape,
   input  logic signed [VALUE_WIDTH-1:0] pa,
   input  logic signed [VALUE_WIDTH-1:0] pb,
   input  logic signed [VALUE_WIDTH-1:0] pc,
   input  logic signed [VALUE_WIDTH-1:0] pd,
   output logic                          out_valid,
   output logic [VALUE_WIDTH:0]          rem,
   output logic [VALUE_WIDTH-1:0]        den,
   output deg_sel_type                   deg_sel,
   output logic                          l_neg,
   output logic                          r_neg,
   output logic [VALUE_WIDTH-1:0]        l_base,
   output logic [VALUE_WIDTH-1:0]        r_base,
   output logic [PROD_WIDTH-1:0]         l_prod,
   output logic [PROD_WIDTH-1:0]         r_prod
);

   localparam logic [DEGREE_FRAC_BITS:0] ONE = {1'b1, {DEGREE_FRAC_BITS{1'b0}}};

   logic signed [VALUE_WIDTH:0] ea, eb, ec, ed, ex;
   logic signed [VALUE_WIDTH:0] num_s, den_s;
   logic signed [VALUE_WIDTH:0] lb_s, lt_s, rb_s, rt_s, ldiff, rdiff;
   logic [VALUE_WIDTH:0]        lmag_w, rmag_w;
   logic [DEGREE_FRAC_BITS:0]   g;
   deg_sel_type                 sel;
   logic                        use_slope;

   logic                        valid_ff;
   logic [VALUE_WIDTH:0]        rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]      den_ff, den_in;
   deg_sel_type                 sel_ff, sel_in;
   logic                        ln_ff, ln_in, rn_ff, rn_in;
   logic [VALUE_WIDTH-1:0]      lbase_ff, lbase_in, rbase_ff, rbase_in;
   logic [PROD_WIDTH-1:0]       lprod_ff, lprod_in, rprod_ff, rprod_in;

   always_comb begin
      ea = {pa[VALUE_WIDTH-1], pa};
      eb = {pb[VALUE_WIDTH-1], pb};
      ec = {pc[VALUE_WIDTH-1], pc};
      ed = {pd[VALUE_WIDTH-1], pd};
      ex = {sample[VALUE_WIDTH-1], sample};
      num_s     = '0;
      den_s     = '0;
      use_slope = 1'b0;
      sel       = DEG_ZERO;
      case (shape)
         SHAPE_TRIANGLE: begin
            if (ea <= ex && ex <= eb) begin
               use_slope = 1'b1; num_s = ex - ea; den_s = eb - ea;
            end else if (eb <= ex && ex <= ed) begin
               use_slope = 1'b1; num_s = ed - ex; den_s = ed - eb;
            end
         end
         SHAPE_TRAPEZOID: begin
            if (ea <= ex && ex <= eb) begin
               use_slope = 1'b1; num_s = ex - ea; den_s = eb - ea;
            end else if (eb <= ex && ex <= ec) begin
               sel = DEG_ONE;
            end else if (ec <= ex && ex <= ed) begin
               use_slope = 1'b1; num_s = ed - ex; den_s = ed - ec;
            end
         end
         SHAPE_RISING: begin
            if (ex < ea) begin
               sel = DEG_ZERO;
            end else if (ex <= ed) begin
               use_slope = 1'b1; num_s = ex - ea; den_s = ed - ea;
            end else begin
               sel = DEG_ONE;
            end
         end
         default: begin
            if (ex < ea) begin
               sel = DEG_ONE;
            end else if (ex <= ed) begin
               use_slope = 1'b1; num_s = ed - ex; den_s = ed - ea;
            end else begin
               sel = DEG_ZERO;
            end
         end
      endcase
      // zero-width edge under the sample reads as full degree
      if (use_slope) begin
         sel = (den_s == '0) ? DEG_ONE : DEG_QUOTIENT;
      end

      // inverse edges: base and target per side
      case (shape)
         SHAPE_TRIANGLE:  begin lb_s = ea; lt_s = eb; rb_s = ed; rt_s = eb; end
         SHAPE_TRAPEZOID: begin lb_s = ea; lt_s = eb; rb_s = ed; rt_s = ec; end
         SHAPE_RISING:    begin lb_s = ea; lt_s = ed; rb_s = ea; rt_s = ed; end
         default:         begin lb_s = ed; lt_s = ea; rb_s = ed; rt_s = ea; end
      endcase
      ldiff  = lt_s - lb_s;
      rdiff  = rt_s - rb_s;
      lmag_w = ldiff[VALUE_WIDTH] ? $unsigned(-ldiff) : $unsigned(ldiff);
      rmag_w = rdiff[VALUE_WIDTH] ? $unsigned(-rdiff) : $unsigned(rdiff);
      g      = (degree_in > ONE) ? ONE : degree_in;

      if (!func) begin
         rem_in   = {1'b0, num_s[VALUE_WIDTH-1:0]};
         den_in   = den_s[VALUE_WIDTH-1:0];
         sel_in   = sel;
         ln_in    = 1'b0;
         rn_in    = 1'b0;
         lbase_in = '0;
         rbase_in = '0;
         lprod_in = '0;
         rprod_in = '0;
      end else begin
         rem_in   = '0;
         den_in   = '0;
         sel_in   = DEG_ZERO;
         ln_in    = ldiff[VALUE_WIDTH];
         rn_in    = rdiff[VALUE_WIDTH];
         lbase_in = lb_s[VALUE_WIDTH-1:0];
         rbase_in = rb_s[VALUE_WIDTH-1:0];
         lprod_in = lmag_w[VALUE_WIDTH-1:0] * g;
         rprod_in = rmag_w[VALUE_WIDTH-1:0] * g;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff   <= rem_in;
         den_ff   <= den_in;
         sel_ff   <= sel_in;
         ln_ff    <= ln_in;
         rn_ff    <= rn_in;
         lbase_ff <= lbase_in;
         rbase_ff <= rbase_in;
         lprod_ff <= lprod_in;
         rprod_ff <= rprod_in;
      end
   end

   assign out_valid = valid_ff;
   assign rem       = rem_ff;
   assign den       = den_ff;
   assign deg_sel   = sel_ff;
   assign l_neg     = ln_ff;
   assign r_neg     = rn_ff;
   assign l_base    = lbase_ff;
   assign r_base    = rbase_ff;
   assign l_prod    = lprod_ff;
   assign r_prod    = rprod_ff;

endmodule

FILE: hdl/fmu_div_step.sv
// One restoring-division stage: one quotient bit per stage, side data carried along.
// No package dependencies.
module fmu_div_step #(
   parameter int VALUE_WIDTH      = 16,
   parameter int DEGREE_FRAC_BITS = 15,
   parameter int SIDE_WIDTH       = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [VALUE_WIDTH:0]        in_rem,
   input  logic [VALUE_WIDTH-1:0]      in_den,
   input  logic [DEGREE_FRAC_BITS:0]   in_quo,
   input  logic [SIDE_WIDTH-1:0]       in_side,
   output logic                        out_valid,
   output logic [VALUE_WIDTH:0]        out_rem,
   output logic [VALUE_WIDTH-1:0]      out_den,
   output logic [DEGREE_FRAC_BITS:0]   out_quo,
   output logic [SIDE_WIDTH-1:0]       out_side
);

   logic                      qbit;
   logic [VALUE_WIDTH:0]      diff;
   logic                      valid_ff;
   logic [VALUE_WIDTH:0]      rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]    den_ff;
   logic [DEGREE_FRAC_BITS:0] quo_ff, quo_in;
   logic [SIDE_WIDTH-1:0]     side_ff;

   // remainder stays below the divisor, so the doubled value fits
   always_comb begin
      qbit   = (in_rem >= {1'b0, in_den});
      diff   = qbit ? (in_rem - {1'b0, in_den}) : in_rem;
      rem_in = {diff[VALUE_WIDTH-1:0], 1'b0};
      quo_in = {in_quo[DEGREE_FRAC_BITS-1:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule

FILE: hdl/fuzzy_membership_unit.sv
// Fuzzy membership unit top level: registers, prep stage, divider chain, output stage.
// Depends on fmu_pkg, fmu_if, fmu_prep and fmu_div_step.
//
//   channel | dir | handshake         | payload
//   req     | in  | valid/ready       | func, sample, degree_in
//   rsp     | out | valid/ready       | degree_out, left_point, right_point
//   csr     | in  | csr_we, no ready  | csr_index, csr_wdata
//
// One transaction enters per cycle unless the response stalls; the pipe is the prep stage,
// one divider stage per quotient bit, then the output register.
// The divider chain sets the depth. Reset clears the valid bits and the configuration registers.
// A stalled response freezes the whole pipe; nothing is dropped or repeated.
module fuzzy_membership_unit
   import fmu_pkg::*;
#(
   parameter int VALUE_WIDTH      = 16,
   parameter int DEGREE_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   fmu_req_if.sink                       req,
   fmu_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [VALUE_WIDTH-1:0]        csr_wdata
);

   localparam int PROD_WIDTH = VALUE_WIDTH + DEGREE_FRAC_BITS + 1;
   localparam int SIDE_WIDTH = DEG_SEL_WIDTH + 2 + 2 * VALUE_WIDTH + 2 * PROD_WIDTH;
   localparam int STEPS      = DEGREE_FRAC_BITS + 1;
   localparam logic [PROD_WIDTH-1:0] HALF = PROD_WIDTH'(1) << (DEGREE_FRAC_BITS - 1);

   // configuration registers
   shape_type                     shape_ff;
   logic signed [VALUE_WIDTH-1:0] pa_ff, pb_ff, pc_ff, pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= SHAPE_TRIANGLE;
         pa_ff    <= '0;
         pb_ff    <= '0;
         pc_ff    <= '0;
         pd_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHAPE_KIND: shape_ff <= shape_type'(csr_wdata[1:0]);
            CSR_POINT_A:    pa_ff    <= csr_wdata;
            CSR_POINT_B:    pb_ff    <= csr_wdata;
            CSR_POINT_C:    pc_ff    <= csr_wdata;
            CSR_POINT_D:    pd_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: move when the output slot is empty or being taken
   logic enable;
   logic out_valid_ff;
   assign enable    = !out_valid_ff || rsp.ready;
   assign req.ready = enable;

   // prep stage
   logic                   p_valid, p_ln, p_rn;
   logic [VALUE_WIDTH:0]   p_rem;
   logic [VALUE_WIDTH-1:0] p_den, p_lbase, p_rbase;
   deg_sel_type            p_sel;
   logic [PROD_WIDTH-1:0]  p_lprod, p_rprod;

   fmu_prep #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DEGREE_FRAC_BITS(DEGREE_FRAC_BITS)
   ) u_prep (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req.valid), .func(req.func), .sample(req.sample),
      .degree_in(req.degree_in), .shape(shape_ff),
      .pa(pa_ff), .pb(pb_ff), .pc(pc_ff), .pd(pd_ff),
      .out_valid(p_valid), .rem(p_rem), .den(p_den), .deg_sel(p_sel),
      .l_neg(p_ln), .r_neg(p_rn), .l_base(p_lbase), .r_base(p_rbase),
      .l_prod(p_lprod), .r_prod(p_rprod)
   );

   // divider chain, one quotient bit per stage
   logic                        st_valid [STEPS+1];
   logic [VALUE_WIDTH:0]        st_rem   [STEPS+1];
   logic [VALUE_WIDTH-1:0]      st_den   [STEPS+1];
   logic [DEGREE_FRAC_BITS:0]   st_quo   [STEPS+1];
   logic [SIDE_WIDTH-1:0]       st_side  [STEPS+1];

   assign st_valid[0] = p_valid;
   assign st_rem[0]   = p_rem;
   assign st_den[0]   = p_den;
   assign st_quo[0]   = '0;
   assign st_side[0]  = {p_sel, p_ln, p_rn, p_lbase, p_rbase, p_lprod, p_rprod};

   for (genvar k = 0; k < STEPS; k++) begin : g_div
      fmu_div_step #(
         .VALUE_WIDTH(VALUE_WIDTH),
         .DEGREE_FRAC_BITS(DEGREE_FRAC_BITS),
         .SIDE_WIDTH(SIDE_WIDTH)
      ) u_step (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(st_valid[k]), .in_rem(st_rem[k]), .in_den(st_den[k]),
         .in_quo(st_quo[k]), .in_side(st_side[k]),
         .out_valid(st_valid[k+1]), .out_rem(st_rem[k+1]), .out_den(st_den[k+1]),
         .out_quo(st_quo[k+1]), .out_side(st_side[k+1])
      );
   end

   // output stage: degree select and rounded inverse points
   logic [DEG_SEL_WIDTH-1:0]  f_sel;
   logic                      f_ln, f_rn;
   logic [VALUE_WIDTH-1:0]    f_lbase, f_rbase, lq, rq;
   logic [PROD_WIDTH-1:0]     f_lprod, f_rprod, lsum, rsum;
   logic [DEGREE_FRAC_BITS:0] deg_in;
   logic [VALUE_WIDTH-1:0]    lp_in, rp_in;
   logic [DEGREE_FRAC_BITS:0] deg_ff;
   logic [VALUE_WIDTH-1:0]    lp_ff, rp_ff;

   always_comb begin
      {f_sel, f_ln, f_rn, f_lbase, f_rbase, f_lprod, f_rprod} = st_side[STEPS];
      case (f_sel)
         DEG_QUOTIENT: deg_in = st_quo[STEPS];
         DEG_ONE:      deg_in = {1'b1, {DEGREE_FRAC_BITS{1'b0}}};
         default:      deg_in = '0;
      endcase
      // round half away from zero on the magnitude, then apply the sign
      lsum  = f_lprod + HALF;
      rsum  = f_rprod + HALF;
      lq    = lsum[DEGREE_FRAC_BITS +: VALUE_WIDTH];
      rq    = rsum[DEGREE_FRAC_BITS +: VALUE_WIDTH];
      lp_in = f_ln ? (f_lbase - lq) : (f_lbase + lq);
      rp_in = f_rn ? (f_rbase - rq) : (f_rbase + rq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= st_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         deg_ff <= deg_in;
         lp_ff  <= lp_in;
         rp_ff  <= rp_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.degree_out  = deg_ff;
   assign rsp.left_point  = lp_ff;
   assign rsp.right_point = rp_ff;

endmodule
